// ===== hdl/keyword_command_parser_macros.svh =====
// Assertion macros shared by the checker of keyword_command_parser.
// No dependencies; the including module must have clock and reset signals.
`ifndef KEYWORD_COMMAND_PARSER_MACROS_SVH
`define KEYWORD_COMMAND_PARSER_MACROS_SVH

// condition that must hold at every edge outside reset
`define KWP_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define KWP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/kwp_pkg.sv =====
// Package for keyword_command_parser: keyword tables, number limits and codes.
// No dependencies.
package kwp_pkg;

   localparam int NUM_KW  = 6;
   localparam int NUM_VAL = 3;
   // first keyword that is followed by a number
   localparam int KW_NUM_BASE = NUM_KW - NUM_VAL;

   localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
      '{"R", "E", "Q", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"S", "W", "I", "T", "C", "H", 8'h00, 8'h00},
      '{"D", "E", "T", "E", "C", "T", 8'h00, 8'h00},
      '{"L", "U", "X", " ", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"K", "E", "L", "V", "I", "N", " ", 8'h00},
      '{"L", "E", "V", "E", "L", " ", 8'h00, 8'h00}
   };
   localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd6, 3'd6, 3'd4, 3'd7, 3'd6};
   // border length of each matched prefix, indexed by prefix length - 1
   localparam logic [2:0] KW_FAIL [NUM_KW][8] = '{
      '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0}
   };

   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [16:0] NUM_SAT    = 17'd65536;
   localparam logic [19:0] NUM_MAX    = 20'd65535;
   localparam logic [16:0] LUX_MAX    = 17'd10000;
   localparam logic [16:0] KELVIN_MIN = 17'd1000;
   localparam logic [16:0] KELVIN_MAX = 17'd40000;
   localparam logic [16:0] LEVEL_MAX  = 17'd100;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_BLANK  = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      CMD_NONE   = 2'd0,
      CMD_REQ    = 2'd1,
      CMD_DATA   = 2'd2,
      CMD_DETECT = 2'd3
   } cmd_type;

   // next match progress of keyword kw after character ch
   function automatic logic [2:0] match_next(input int kw, input logic [2:0] prog,
                                             input logic [7:0] ch);
      logic [2:0] p;
      p = (prog >= KW_LEN[kw]) ? 3'd0 : prog;
      for (int i = 0; i < 7; i++) begin
         if (p != 3'd0 && ch != KW_TEXT[kw][p]) begin
            p = KW_FAIL[kw][p - 3'd1];
         end
      end
      if (ch == KW_TEXT[kw][p]) begin
         p = p + 3'd1;
      end
      return p;
   endfunction

endpackage

// ===== hdl/keyword_command_parser.sv =====
// Keyword command parser: scans a byte stream for command keywords and
// numbers and reports one result per message. Depends on kwp_pkg.
//
// Usage:
//   The request channel (req_valid/req_ready) carries one message byte per
//   request with req_last marking the final byte. A zero byte ends the text;
//   later bytes are ignored until the last mark closes the message.
//   The response channel (rsp_valid/rsp_ready) carries one result per
//   message: the command code and the current lamp state and settings.
// Timing:
//   One request per cycle, sustained except while a last byte waits (see Stall).
//   All six keyword matchers and the three multiply-by-ten number accumulators
//   update in the cycle a byte is taken. The result is registered into the
//   output register in the cycle after the last byte is accepted.
// Stall:
//   While a result waits, non-last bytes are still taken; a last byte waits
//   until the output register is free or drains in the same cycle.
// Reset:
//   Synchronous, active high. Clears all matcher state, the flags and the
//   three value registers, and empties the output register.
module keyword_command_parser
   import kwp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_req,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_command,
   output logic        rsp_lamp_on,
   output logic        rsp_motion_enable,
   output logic [13:0] rsp_lux_threshold,
   output logic [15:0] rsp_color_kelvin,
   output logic [6:0]  rsp_brightness
);

   logic [2:0]  prog_ff   [NUM_KW];
   logic [2:0]  prog_in   [NUM_KW];
   logic        found_ff  [NUM_KW];
   logic        found_in  [NUM_KW];
   phase_type   phase_ff  [NUM_VAL];
   phase_type   phase_in  [NUM_VAL];
   logic [16:0] value_ff  [NUM_VAL];
   logic [16:0] value_in  [NUM_VAL];
   logic        ended_ff, ended_in;
   logic        on_ff, on_in;
   logic        motion_ff, motion_in;
   logic [13:0] thresh_ff, thresh_in;
   logic [15:0] kelvin_ff, kelvin_in;
   logic [6:0]  level_ff, level_in;

   logic        rsp_valid_ff, rsp_valid_in;
   cmd_type     cmd_ff, cmd_in;
   logic        out_on_ff, out_motion_ff;
   logic [13:0] out_thresh_ff;
   logic [15:0] out_kelvin_ff;
   logic [6:0]  out_level_ff;

   logic req_fire;
   logic rsp_load;

   assign req_ready = !rsp_valid_ff || rsp_ready || !req_last;
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = req_fire && req_last;

   always_comb begin
      logic [2:0]  p_nx   [NUM_KW];
      logic        f_nx   [NUM_KW];
      phase_type   ph_nx  [NUM_VAL];
      logic [16:0] v_nx   [NUM_VAL];
      logic [19:0] acc;
      logic        digit;
      logic        blank;

      p_nx     = prog_ff;
      f_nx     = found_ff;
      ph_nx    = phase_ff;
      v_nx     = value_ff;
      ended_in = ended_ff;
      acc      = '0;
      digit    = (req_byte_req >= CH_0) && (req_byte_req <= CH_9);
      blank    = (req_byte_req == CH_SPACE) || (req_byte_req == CH_TAB);

      if (req_fire && !ended_ff) begin
         if (req_byte_req == CH_NUL) begin
            ended_in = 1'b1;
         end else begin
            for (int n = 0; n < NUM_VAL; n++) begin
               case (phase_ff[n])
                  PH_BLANK: begin
                     if (digit) begin
                        v_nx[n]  = {9'd0, req_byte_req - CH_0};
                        ph_nx[n] = PH_DIGITS;
                     end else if (!blank) begin
                        ph_nx[n] = PH_IDLE;
                     end
                  end
                  PH_DIGITS: begin
                     if (digit) begin
                        acc = ({3'b000, value_ff[n]} << 3) + ({3'b000, value_ff[n]} << 1)
                              + {12'd0, req_byte_req - CH_0};
                        v_nx[n] = (acc > NUM_MAX) ? NUM_SAT : acc[16:0];
                     end else begin
                        ph_nx[n] = PH_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            // keyword completion arms its number only from the next byte on
            for (int k = 0; k < NUM_KW; k++) begin
               if (!found_ff[k]) begin
                  p_nx[k] = match_next(k, prog_ff[k], req_byte_req);
                  if (p_nx[k] >= KW_LEN[k]) begin
                     f_nx[k] = 1'b1;
                     p_nx[k] = 3'd0;
                     if (k >= KW_NUM_BASE) begin
                        ph_nx[k - KW_NUM_BASE] = PH_BLANK;
                     end
                  end
               end
            end
         end
      end

      on_in     = on_ff;
      motion_in = motion_ff;
      thresh_in = thresh_ff;
      kelvin_in = kelvin_ff;
      level_in  = level_ff;
      cmd_in    = CMD_NONE;
      if (f_nx[0]) begin
         cmd_in = CMD_REQ;
      end
      if (f_nx[1]) begin
         on_in  = !on_ff;
         cmd_in = CMD_DATA;
      end
      if (f_nx[2]) begin
         motion_in = !motion_ff;
         cmd_in    = CMD_DETECT;
      end
      if ((ph_nx[0] == PH_DIGITS || ph_nx[0] == PH_DONE) && v_nx[0] <= LUX_MAX) begin
         thresh_in = v_nx[0][13:0];
         cmd_in    = CMD_DATA;
      end
      if ((ph_nx[1] == PH_DIGITS || ph_nx[1] == PH_DONE) &&
          v_nx[1] >= KELVIN_MIN && v_nx[1] <= KELVIN_MAX) begin
         kelvin_in = v_nx[1][15:0];
         cmd_in    = CMD_DATA;
      end
      if ((ph_nx[2] == PH_DIGITS || ph_nx[2] == PH_DONE) && v_nx[2] <= LEVEL_MAX) begin
         level_in = v_nx[2][6:0];
         cmd_in   = CMD_DATA;
      end

      // message end: settings commit, per-message state clears
      if (rsp_load) begin
         for (int k = 0; k < NUM_KW; k++) begin
            prog_in[k]  = 3'd0;
            found_in[k] = 1'b0;
         end
         for (int n = 0; n < NUM_VAL; n++) begin
            phase_in[n] = PH_IDLE;
            value_in[n] = '0;
         end
         ended_in = 1'b0;
      end else begin
         prog_in   = p_nx;
         found_in  = f_nx;
         phase_in  = ph_nx;
         value_in  = v_nx;
         on_in     = on_ff;
         motion_in = motion_ff;
         thresh_in = thresh_ff;
         kelvin_in = kelvin_ff;
         level_in  = level_ff;
      end
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_KW; k++) begin
            prog_ff[k]  <= 3'd0;
            found_ff[k] <= 1'b0;
         end
         for (int n = 0; n < NUM_VAL; n++) begin
            phase_ff[n] <= PH_IDLE;
            value_ff[n] <= '0;
         end
         ended_ff     <= 1'b0;
         on_ff        <= 1'b0;
         motion_ff    <= 1'b0;
         thresh_ff    <= '0;
         kelvin_ff    <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prog_ff      <= prog_in;
         found_ff     <= found_in;
         phase_ff     <= phase_in;
         value_ff     <= value_in;
         ended_ff     <= ended_in;
         on_ff        <= on_in;
         motion_ff    <= motion_in;
         thresh_ff    <= thresh_in;
         kelvin_ff    <= kelvin_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         cmd_ff        <= cmd_in;
         out_on_ff     <= on_in;
         out_motion_ff <= motion_in;
         out_thresh_ff <= thresh_in;
         out_kelvin_ff <= kelvin_in;
         out_level_ff  <= level_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_command       = cmd_ff;
   assign rsp_lamp_on       = out_on_ff;
   assign rsp_motion_enable = out_motion_ff;
   assign rsp_lux_threshold = out_thresh_ff;
   assign rsp_color_kelvin  = out_kelvin_ff;
   assign rsp_brightness    = out_level_ff;

endmodule

// ===== hdl/kwp_checker.sv =====
// Port-level checker for keyword_command_parser, bound to the top level.
// Depends on keyword_command_parser_macros.svh.
`include "keyword_command_parser_macros.svh"

module kwp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_byte_req,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_command,
   input logic        rsp_lamp_on,
   input logic        rsp_motion_enable,
   input logic [13:0] rsp_lux_threshold,
   input logic [15:0] rsp_color_kelvin,
   input logic [6:0]  rsp_brightness
);

   logic [41:0] rsp_payload;
   logic        rsp_stall;
   logic        last_take;
   logic        quiet_take;
   logic        ranges_ok;

   assign rsp_payload = {rsp_command, rsp_lamp_on, rsp_motion_enable, rsp_lux_threshold,
                         rsp_color_kelvin, rsp_brightness};
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign last_take   = req_valid && req_ready && req_last;
   // non-last byte taken while the output is empty
   assign quiet_take  = req_valid && req_ready && !req_last && !rsp_valid;
   assign ranges_ok   = rsp_lux_threshold <= 14'd10000 && rsp_brightness <= 7'd100 &&
                        (rsp_color_kelvin == 16'd0 ||
                         (rsp_color_kelvin >= 16'd1000 && rsp_color_kelvin <= 16'd40000));

   // stalled result holds
   `KWP_ASSERT_NEXT(a_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "rsp changed")
   // a last byte always yields a response next cycle
   `KWP_ASSERT_NEXT(a_last_gives_rsp, last_take, rsp_valid, "missing response after last")
   // a non-last byte never invents a response
   `KWP_ASSERT_NEXT(a_no_extra_rsp, quiet_take, !rsp_valid, "response without last byte")
   // settings stay within their legal ranges
   `KWP_ASSERT(a_ranges, !rsp_valid || ranges_ok, "setting out of range")

endmodule

bind keyword_command_parser kwp_checker u_kwp_checker (.*);
